### rtl/rpn_stack_calculator_top_defines.svh
// Assertion helpers for the calculator checker.
// Both expect clk and rst to be visible where they are used.
`ifndef RPN_STACK_CALCULATOR_TOP_DEFINES_SVH
`define RPN_STACK_CALCULATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rpnc_pkg.sv
package rpnc_pkg;

  localparam int STACK_DEPTH = 10;
  localparam int MAX_DIGITS  = 10;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int DIG_W   = $clog2(MAX_DIGITS + 2);
  localparam int DEPTH_W = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BADCHAR   = 3'd2;
  localparam logic [2:0] ST_DIGITS    = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       token_end;
    logic       expr_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] answer;
    logic [DEPTH_W-1:0] depth;
    logic               total_valid;
  } out_item_t;

  // push: shift down and write top; combine: replace top two by value
  typedef struct packed {
    logic        push;
    logic        combine;
    logic [31:0] value;
  } stk_cmd_t;

endpackage

### rtl/rpnc_stack.sv
module rpnc_stack
  import rpnc_pkg::*;
(
  input  logic        clk,
  input  stk_cmd_t    cmd,
  output logic [31:0] top,
  output logic [31:0] second
);

  // entry[0] is the top of stack; only entry[0] and entry[1] are read, each at a fixed place
  logic [31:0] entry [STACK_DEPTH];

  genvar i;
  for (i = 0; i < STACK_DEPTH; i++) begin : g_entry
    if (i == 0) begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.push || cmd.combine) begin
          entry[0] <= cmd.value;
        end
      end
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      always_ff @(posedge clk) begin
        if (cmd.push) begin
          entry[i] <= entry[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.push) begin
          entry[i] <= entry[i-1];
        end else if (cmd.combine) begin
          entry[i] <= entry[i+1];
        end
      end
    end
  end

  assign top    = entry[0];
  assign second = entry[1];

endmodule

### rtl/rpnc_core.sv
module rpnc_core
  import rpnc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_item_t  item,
  output out_item_t res
);

  typedef enum logic [1:0] {TK_START, TK_NUM, TK_OP, TK_BAD} kind_t;
  typedef enum logic [1:0] {OP_NONE, OP_ADD, OP_SUB, OP_MUL} op_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  kind_t            token_kind,   token_kind_next;
  op_t              pending_op,   pending_op_next;
  logic [31:0]      number_accum, number_accum_next;
  logic [DIG_W-1:0] digit_count,  digit_count_next;
  logic [2:0]       error_code,   error_code_next;
  logic [31:0]      last_answer,  last_answer_next;
  logic [CNT_W-1:0] stack_count,  stack_count_next;

  stk_cmd_t    cmd;
  logic [31:0] top, second;
  logic [31:0] alu;
  logic [31:0] accum_mac;
  logic        is_digit;
  logic        etok;
  op_t         op_sel;

  rpnc_stack u_stack (
    .clk    (clk),
    .cmd    (cmd),
    .top    (top),
    .second (second)
  );

  assign etok     = item.token_end | item.expr_end;
  assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
  // accum * 10 + digit, wrapping at 32 bits
  assign accum_mac = {number_accum[28:0], 3'b000} + {number_accum[30:0], 1'b0}
                   + {28'd0, item.char_code[3:0]};

  // operator of the token this item belongs to
  always_comb begin
    op_sel = pending_op;
    if (token_kind == TK_START) begin
      case (item.char_code)
        CH_PLUS:  op_sel = OP_ADD;
        CH_MINUS: op_sel = OP_SUB;
        CH_TIMES: op_sel = OP_MUL;
        default:  op_sel = OP_NONE;
      endcase
    end
  end

  always_comb begin
    case (op_sel)
      OP_ADD:  alu = second + top;
      OP_SUB:  alu = second - top;
      default: alu = second * top;
    endcase
  end

  always_comb begin
    token_kind_next   = token_kind;
    pending_op_next   = pending_op;
    number_accum_next = number_accum;
    digit_count_next  = digit_count;
    error_code_next   = error_code;
    last_answer_next  = last_answer;
    stack_count_next  = stack_count;
    cmd               = '0;

    // once an error is latched, characters only end tokens
    if (error_code == ST_OK) begin
      if (token_kind == TK_START) begin
        case (item.char_code)
          CH_PLUS:  begin token_kind_next = TK_OP; pending_op_next = OP_ADD; end
          CH_MINUS: begin token_kind_next = TK_OP; pending_op_next = OP_SUB; end
          CH_TIMES: begin token_kind_next = TK_OP; pending_op_next = OP_MUL; end
          default:  token_kind_next = TK_NUM;
        endcase
      end
      if (token_kind_next == TK_NUM || token_kind_next == TK_BAD) begin
        if (digit_count <= DIG_W'(MAX_DIGITS)) begin
          digit_count_next = digit_count + DIG_W'(1);
        end
        if (is_digit) begin
          if (token_kind_next == TK_NUM) begin
            number_accum_next = accum_mac;
          end
        end else begin
          token_kind_next = TK_BAD;
        end
      end
      if (etok) begin
        if (token_kind_next == TK_OP) begin
          if (stack_count < CNT_W'(2)) begin
            error_code_next = ST_UNDERFLOW;
          end else begin
            cmd.combine      = en;
            cmd.value        = alu;
            stack_count_next = stack_count - CNT_W'(1);
            last_answer_next = alu;
          end
        end else if (digit_count_next > DIG_W'(MAX_DIGITS)) begin
          error_code_next = ST_DIGITS;
        end else if (token_kind_next == TK_BAD) begin
          error_code_next = ST_BADCHAR;
        end else if (stack_count >= CNT_W'(STACK_DEPTH)) begin
          error_code_next = ST_FULL;
        end else begin
          cmd.push         = en;
          cmd.value        = number_accum_next;
          stack_count_next = stack_count + CNT_W'(1);
        end
      end
    end

    res.status      = error_code_next;
    res.answer      = $signed(last_answer_next);
    res.depth       = DEPTH_W'(stack_count_next);
    res.total_valid = item.expr_end && (error_code_next == ST_OK);

    if (etok) begin
      token_kind_next   = TK_START;
      pending_op_next   = OP_NONE;
      number_accum_next = '0;
      digit_count_next  = '0;
    end
    if (item.expr_end) begin
      stack_count_next = '0;
      last_answer_next = '0;
      error_code_next  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_kind   <= TK_START;
      pending_op   <= OP_NONE;
      number_accum <= '0;
      digit_count  <= '0;
      error_code   <= ST_OK;
      last_answer  <= '0;
      stack_count  <= '0;
    end else if (en) begin
      token_kind   <= token_kind_next;
      pending_op   <= pending_op_next;
      number_accum <= number_accum_next;
      digit_count  <= digit_count_next;
      error_code   <= error_code_next;
      last_answer  <= last_answer_next;
      stack_count  <= stack_count_next;
    end
  end

endmodule

### rtl/rpn_stack_calculator_top.sv
// Reverse-Polish integer calculator, one ASCII character per item.
// Input channel char_*: char_code plus token_end / expr_end flags; expr_end
// also ends the current token. Output channel res_*: one item per input item
// with sticky status, the latest operator answer, the stack depth and
// total_valid on a clean end of expression.
// Both channels: an item moves on a clock edge with valid high and stall low.
// An accepted character is held in an input register and its result is
// registered on the next edge the output is free. Throughput: one character
// per cycle while res_stall is low; the parser, the stack shift and the
// 32x32 multiply all finish between the input and result registers.
// When res_stall holds a waiting result, the input register keeps at most one
// more character and char_stall rises until the result is taken.
// Reset (rst, synchronous) empties both registers, clears the stack count,
// the answer, the error code and the token state. Stack contents are not
// cleared; an entry is only read after it was pushed.
module rpn_stack_calculator_top
  import rpnc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  in_item_t  char_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      pend_valid;
  in_item_t  pend_item;
  logic      advance;
  logic      take;
  out_item_t core_res;

  assign advance    = pend_valid && (!res_valid || !res_stall);
  assign char_stall = pend_valid && !advance;
  assign take       = char_valid && !char_stall;

  rpnc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (pend_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      pend_valid <= take || (pend_valid && !advance);
      res_valid  <= advance || (res_valid && res_stall);
    end
    if (take) begin
      pend_item <= char_item;
    end
    if (advance) begin
      res_item <= core_res;
    end
  end

endmodule

### rtl/rpnc_checker.sv
`include "rpn_stack_calculator_top_defines.svh"

module rpnc_checker
  import rpnc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      char_stall,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  `RPNC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item), "stalled result changed")
  `RPNC_ASSERT_NOW(a_total_clean, res_valid && res_item.total_valid, res_item.status == ST_OK, "total with error")
  `RPNC_ASSERT_NOW(a_depth_bound, res_valid, 32'(res_item.depth) <= STACK_DEPTH, "depth beyond stack")
  `RPNC_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid && !char_stall, "output busy after reset")

endmodule

bind rpn_stack_calculator_top rpnc_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .char_stall (char_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_item   (res_item)
);
